[src/nrsi_pkg.sv]
// Shared types, constants and helper functions for the nearest-neighbour source index unit.
package nrsi_pkg;

    // Largest source or destination dimension in pixels
    localparam int MAX_DIM  = 4096;

    // Field and datapath widths
    localparam int COORD_W  = $clog2(MAX_DIM);      // coordinate, 0 .. MAX_DIM-1
    localparam int DIM_W    = COORD_W + 1;          // dimension, 1 .. MAX_DIM
    localparam int DEN_W    = DIM_W + 1;            // divisor, up to 2*MAX_DIM
    localparam int NUM_W    = 2 * COORD_W + 1;      // dividend (2i+1)*S
    localparam int LIM_W    = 2 * COORD_W + 2;      // S * divisor
    localparam int MODE_W   = 1;
    localparam int PSIZE_W  = 5;
    localparam int STRIDE_W = 16;
    localparam int OFF_W    = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STRIDE_W;
    localparam int ROWP_W   = COORD_W + STRIDE_W;   // row * stride
    localparam int COLP_W   = COORD_W + PSIZE_W;    // column * pixel size

    // Pipeline stage numbering
    localparam int ST_IN    = 0;                    // input register
    localparam int ST_MUL   = 1;                    // dividend and limit products
    localparam int ST_SAT   = 2;                    // clamp decision, divider load
    localparam int ST_CLAMP = ST_SAT + COORD_W + 1; // one quotient bit per stage before this
    localparam int ST_PROD  = ST_CLAMP + 1;         // offset products
    localparam int ST_OUT   = ST_PROD + 1;          // offset sum, output register
    localparam int N_STAGES = ST_OUT + 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_SCALE_MODE = 3'd4,
        CFG_PIXEL_SIZE = 3'd5,
        CFG_SRC_STRIDE = 3'd6
    } cfg_reg_t;

    // Sampling modes
    typedef enum logic [MODE_W-1:0] {
        MODE_CENTRE = 1'b0,
        MODE_FLOOR  = 1'b1
    } scale_mode_t;

    // Divider stage contents
    typedef struct packed {
        logic               sat;
        logic [NUM_W-1:0]   rem;
        logic [COORD_W-1:0] quo;
    } div_t;

    // Zero reads as one, oversize reads as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > DIM_W'(MAX_DIM))
            begin
                r = DIM_W'(MAX_DIM);
            end
            return r;
        end
    endfunction

endpackage

[src/nrsi_req_if.sv]
// Channel interfaces: destination coordinate requests and source index responses.
interface nrsi_req_if;
    logic                          valid;
    logic                          ready;
    logic [nrsi_pkg::COORD_W-1:0]  dst_col;
    logic [nrsi_pkg::COORD_W-1:0]  dst_row;

    modport source (output valid, output dst_col, output dst_row, input ready);
    modport sink   (input valid, input dst_col, input dst_row, output ready);
endinterface

interface nrsi_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nrsi_pkg::COORD_W-1:0]  src_col;
    logic [nrsi_pkg::COORD_W-1:0]  src_row;
    logic [nrsi_pkg::OFF_W-1:0]    src_offset;

    modport source (output valid, output src_col, output src_row, output src_offset,
                    input ready);
    modport sink   (input valid, input src_col, input src_row, input src_offset,
                    output ready);
endinterface

[src/nrsi_coord_map.sv]
// One coordinate lane: exact rational scaling by a pipelined restoring divider, then clamp.
module nrsi_coord_map (
    input  logic                                          clk,
    input  logic [nrsi_pkg::ST_CLAMP:nrsi_pkg::ST_MUL]    en,
    input  logic [nrsi_pkg::COORD_W-1:0]                  coord,
    input  logic [nrsi_pkg::DIM_W-1:0]                    s_dim,
    input  logic [nrsi_pkg::DIM_W-1:0]                    d_dim,
    input  nrsi_pkg::scale_mode_t                         mode,
    output logic [nrsi_pkg::COORD_W-1:0]                  mapped
);

    logic [nrsi_pkg::DIM_W-1:0]     odd;
    logic [nrsi_pkg::DEN_W-1:0]     den;
    logic [2*nrsi_pkg::DIM_W-1:0]   num_full;
    logic [nrsi_pkg::DIM_W+nrsi_pkg::DEN_W-1:0] lim_full;
    logic [nrsi_pkg::NUM_W-1:0]     num_reg;
    logic [nrsi_pkg::LIM_W-1:0]     lim_reg;
    nrsi_pkg::div_t                 div_reg [0:nrsi_pkg::COORD_W];
    nrsi_pkg::div_t                 load_next;
    logic [nrsi_pkg::COORD_W-1:0]   mapped_next;
    logic [nrsi_pkg::COORD_W-1:0]   mapped_reg;

    // Centre mode uses (2i+1)*S / 2D, floor mode i*S / D
    always_comb
    begin
        if (mode == nrsi_pkg::MODE_CENTRE)
        begin
            odd = {coord, 1'b1};
            den = {d_dim, 1'b0};
        end
        else
        begin
            odd = {1'b0, coord};
            den = {1'b0, d_dim};
        end
        num_full = odd * s_dim;
        lim_full = s_dim * den;
    end

    // Stage: dividend and clamp limit
    always_ff @(posedge clk)
    begin
        if (en[nrsi_pkg::ST_MUL])
        begin
            num_reg <= num_full[nrsi_pkg::NUM_W-1:0];
            lim_reg <= lim_full[nrsi_pkg::LIM_W-1:0];
        end
    end

    // Stage: quotient reaches S exactly when dividend >= S * divisor
    always_comb
    begin
        load_next.sat = ({1'b0, num_reg} >= lim_reg);
        load_next.rem = num_reg;
        load_next.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[nrsi_pkg::ST_SAT])
        begin
            div_reg[0] <= load_next;
        end
    end

    // Restoring divider, most significant quotient bit first
    for (genvar j = 0; j < nrsi_pkg::COORD_W; j++)
    begin : g_div
        localparam int BIT = nrsi_pkg::COORD_W - 1 - j;
        localparam int STG = nrsi_pkg::ST_SAT + 1 + j;

        logic [nrsi_pkg::NUM_W-1:0] trial;
        nrsi_pkg::div_t             step_next;

        always_comb
        begin
            trial     = nrsi_pkg::NUM_W'(den) << BIT;
            step_next = div_reg[j];
            if (div_reg[j].rem >= trial)
            begin
                step_next.rem      = div_reg[j].rem - trial;
                step_next.quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[STG])
            begin
                div_reg[j+1] <= step_next;
            end
        end
    end

    // Stage: clamp to S-1
    always_comb
    begin
        if (div_reg[nrsi_pkg::COORD_W].sat)
        begin
            mapped_next = nrsi_pkg::COORD_W'(s_dim - nrsi_pkg::DIM_W'(1));
        end
        else
        begin
            mapped_next = div_reg[nrsi_pkg::COORD_W].quo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[nrsi_pkg::ST_CLAMP])
        begin
            mapped_reg <= mapped_next;
        end
    end

    assign mapped = mapped_reg;

endmodule

[src/nearest_resize_source_index.sv]
// Top level of the nearest-neighbour scaler source index unit.
//
// For each destination pixel (dst_col, dst_row) the unit returns the source column
// and row that a nearest-neighbour scaler copies, and the byte offset
// src_row*src_stride + src_col*pixel_size (modulo 2^28). Centre mode gives
// floor((2i+1)*S/(2D)), floor mode floor(i*S/D), both exact and clamped to S-1;
// size registers reading 0 act as 1 and sizes above 4096 act as 4096. One
// transaction is accepted per clock while the pipeline has room, and each passes
// through 18 register stages; the divider resolves one quotient bit per stage over
// 12 stages. Every stage holds its own valid bit, so a stalled response only blocks
// input once the pipeline behind it is full. Configuration registers are written
// through cfg_we/cfg_idx/cfg_wdata; the user must write them only while no
// transaction is in flight, which the unit itself does not enforce.
module nearest_resize_source_index (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nrsi_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [nrsi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    nrsi_req_if.sink                          req,
    nrsi_rsp_if.source                        rsp
);

    // Configuration registers
    logic [nrsi_pkg::DIM_W-1:0]     src_width_reg;
    logic [nrsi_pkg::DIM_W-1:0]     src_height_reg;
    logic [nrsi_pkg::DIM_W-1:0]     dst_width_reg;
    logic [nrsi_pkg::DIM_W-1:0]     dst_height_reg;
    nrsi_pkg::scale_mode_t          scale_mode_reg;
    logic [nrsi_pkg::PSIZE_W-1:0]   pixel_size_reg;
    logic [nrsi_pkg::STRIDE_W-1:0]  src_stride_reg;

    // Pipeline control
    logic [nrsi_pkg::N_STAGES:0]    en;
    logic [nrsi_pkg::N_STAGES-1:0]  vld_next;
    logic [nrsi_pkg::N_STAGES-1:0]  vld_reg;

    // Datapath
    logic [nrsi_pkg::COORD_W-1:0]   col_in_reg;
    logic [nrsi_pkg::COORD_W-1:0]   row_in_reg;
    logic [nrsi_pkg::COORD_W-1:0]   col_map;
    logic [nrsi_pkg::COORD_W-1:0]   row_map;
    logic [nrsi_pkg::ROWP_W-1:0]    row_prod_reg;
    logic [nrsi_pkg::COLP_W-1:0]    col_prod_reg;
    logic [nrsi_pkg::COORD_W-1:0]   col_prod_stg_reg;
    logic [nrsi_pkg::COORD_W-1:0]   row_prod_stg_reg;
    logic [nrsi_pkg::OFF_W-1:0]     off_next;
    logic [nrsi_pkg::OFF_W-1:0]     off_reg;
    logic [nrsi_pkg::COORD_W-1:0]   col_out_reg;
    logic [nrsi_pkg::COORD_W-1:0]   row_out_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= nrsi_pkg::DIM_W'(1);
            src_height_reg <= nrsi_pkg::DIM_W'(1);
            dst_width_reg  <= nrsi_pkg::DIM_W'(1);
            dst_height_reg <= nrsi_pkg::DIM_W'(1);
            scale_mode_reg <= nrsi_pkg::MODE_CENTRE;
            pixel_size_reg <= nrsi_pkg::PSIZE_W'(1);
            src_stride_reg <= nrsi_pkg::STRIDE_W'(1);
        end
        else if (cfg_we)
        begin
            case (nrsi_pkg::cfg_reg_t'(cfg_idx))
                nrsi_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[nrsi_pkg::DIM_W-1:0];
                nrsi_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_wdata[nrsi_pkg::DIM_W-1:0];
                nrsi_pkg::CFG_DST_WIDTH:  dst_width_reg  <= cfg_wdata[nrsi_pkg::DIM_W-1:0];
                nrsi_pkg::CFG_DST_HEIGHT: dst_height_reg <= cfg_wdata[nrsi_pkg::DIM_W-1:0];
                nrsi_pkg::CFG_SCALE_MODE:
                    scale_mode_reg <= nrsi_pkg::scale_mode_t'(cfg_wdata[nrsi_pkg::MODE_W-1:0]);
                nrsi_pkg::CFG_PIXEL_SIZE: pixel_size_reg <= cfg_wdata[nrsi_pkg::PSIZE_W-1:0];
                nrsi_pkg::CFG_SRC_STRIDE: src_stride_reg <= cfg_wdata[nrsi_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage moves when it is empty or the stage after it moves
    always_comb
    begin
        en[nrsi_pkg::N_STAGES] = rsp.ready;
        for (int k = nrsi_pkg::N_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = req.valid;
        end
        for (int k = 1; k < nrsi_pkg::N_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign req.ready = en[nrsi_pkg::ST_IN];

    // Input stage
    always_ff @(posedge clk)
    begin
        if (en[nrsi_pkg::ST_IN])
        begin
            col_in_reg <= req.dst_col;
            row_in_reg <= req.dst_row;
        end
    end

    // Column and row lanes
    nrsi_coord_map u_col_map (
        .clk    (clk),
        .en     (en[nrsi_pkg::ST_CLAMP:nrsi_pkg::ST_MUL]),
        .coord  (col_in_reg),
        .s_dim  (nrsi_pkg::eff_dim(src_width_reg)),
        .d_dim  (nrsi_pkg::eff_dim(dst_width_reg)),
        .mode   (scale_mode_reg),
        .mapped (col_map)
    );

    nrsi_coord_map u_row_map (
        .clk    (clk),
        .en     (en[nrsi_pkg::ST_CLAMP:nrsi_pkg::ST_MUL]),
        .coord  (row_in_reg),
        .s_dim  (nrsi_pkg::eff_dim(src_height_reg)),
        .d_dim  (nrsi_pkg::eff_dim(dst_height_reg)),
        .mode   (scale_mode_reg),
        .mapped (row_map)
    );

    // Offset products
    always_ff @(posedge clk)
    begin
        if (en[nrsi_pkg::ST_PROD])
        begin
            row_prod_reg     <= row_map * src_stride_reg;
            col_prod_reg     <= col_map * pixel_size_reg;
            col_prod_stg_reg <= col_map;
            row_prod_stg_reg <= row_map;
        end
    end

    // Offset sum, wraps at the field width
    assign off_next = nrsi_pkg::OFF_W'(row_prod_reg) + nrsi_pkg::OFF_W'(col_prod_reg);

    always_ff @(posedge clk)
    begin
        if (en[nrsi_pkg::ST_OUT])
        begin
            off_reg     <= off_next;
            col_out_reg <= col_prod_stg_reg;
            row_out_reg <= row_prod_stg_reg;
        end
    end

    assign rsp.valid      = vld_reg[nrsi_pkg::ST_OUT];
    assign rsp.src_col    = col_out_reg;
    assign rsp.src_row    = row_out_reg;
    assign rsp.src_offset = off_reg;

endmodule

[src/nrsi_checker.sv]
// Port-level checks on the source index unit, bound to the top level.
module nrsi_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nrsi_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [nrsi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              req_valid,
    input  logic                              req_ready,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic [nrsi_pkg::COORD_W-1:0]      rsp_src_col,
    input  logic [nrsi_pkg::COORD_W-1:0]      rsp_src_row,
    input  logic [nrsi_pkg::OFF_W-1:0]        rsp_src_offset
);

    logic [nrsi_pkg::DIM_W-1:0]     width_reg;
    logic [nrsi_pkg::DIM_W-1:0]     height_reg;
    logic [nrsi_pkg::DIM_W-1:0]     width_eff;
    logic [nrsi_pkg::DIM_W-1:0]     height_eff;
    logic [$clog2(nrsi_pkg::N_STAGES+2)-1:0] pend_reg;
    logic [$clog2(nrsi_pkg::N_STAGES+2)-1:0] pend_next;

    // Shadow of the source size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nrsi_pkg::DIM_W'(1);
            height_reg <= nrsi_pkg::DIM_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_idx == nrsi_pkg::CFG_SRC_WIDTH)
            begin
                width_reg <= cfg_wdata[nrsi_pkg::DIM_W-1:0];
            end
            if (cfg_idx == nrsi_pkg::CFG_SRC_HEIGHT)
            begin
                height_reg <= cfg_wdata[nrsi_pkg::DIM_W-1:0];
            end
        end
    end

    assign width_eff  = nrsi_pkg::eff_dim(width_reg);
    assign height_eff = nrsi_pkg::eff_dim(height_reg);

    // Transactions accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (req_valid && req_ready && !(rsp_valid && rsp_ready))
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!(req_valid && req_ready) && rsp_valid && rsp_ready)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_col)
            && $stable(rsp_src_row) && $stable(rsp_src_offset))
        else $error("stalled response changed");

    // A free output side never blocks the input
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("input blocked while output ready");

    // No response without an outstanding transaction, and no more in flight than stages
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != '0)
        else $error("response without request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= nrsi_pkg::N_STAGES)
        else $error("more transactions in flight than stages");

    // Coordinates stay inside the source image
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp_src_col} < width_eff) && ({1'b0, rsp_src_row} < height_eff))
        else $error("source coordinate beyond clamp");

endmodule

bind nearest_resize_source_index nrsi_checker u_nrsi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_src_col    (rsp.src_col),
    .rsp_src_row    (rsp.src_row),
    .rsp_src_offset (rsp.src_offset)
);
